FILE: sv/additive_harmonic_voice_unit_defines.svh
// ----------------------------------------------------------------------------
// Additive harmonic voice assertion macros
// Shared property shapes for the checks at the end of the voice top level.
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_HARMONIC_VOICE_UNIT_DEFINES_SVH
`define ADDITIVE_HARMONIC_VOICE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and off while reset is held.
`define AHV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and off while reset is held.
`define AHV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ahv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive harmonic voice package
// Types, register codes and fixed constants shared by the voice modules.
// ----------------------------------------------------------------------------
package ahv_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int RES_W      = SAMPLE_W + 1;
    localparam int IDX_W      = 24;
    localparam int ENV_W      = 25;
    localparam int ENV_FRAC   = 24;
    localparam int MAG_FRAC   = 16;

    localparam logic [ENV_W-1:0] ENV_ONE  = 25'h100_0000;
    localparam logic [ENV_W-1:0] ENV_HALF = 25'h080_0000;

    localparam logic [RES_W-1:0]    POS_LIMIT = 17'd32767;
    localparam logic [RES_W-1:0]    NEG_LIMIT = 17'd32768;
    localparam logic [SAMPLE_W-1:0] POS_SAT   = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] NEG_SAT   = 16'h8000;

    // pi/2 in Q2.30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Harmonic weights 1, 0.5, 0.35, 0.15 in Q1.16.
    localparam int HARM_W = 17;
    localparam logic [HARM_W-1:0] HARM_WEIGHT [4] = '{
        17'd65536, 17'd32768, 17'd22938, 17'd9830
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP     = 3'd0,
        CFG_NOTE_LENGTH    = 3'd1,
        CFG_LOUDNESS       = 3'd2,
        CFG_ATTACK_LENGTH  = 3'd3,
        CFG_ATTACK_SLOPE   = 3'd4,
        CFG_RELEASE_LENGTH = 3'd5,
        CFG_RELEASE_SLOPE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [23:0] note_length;
        logic [15:0] loudness;
        logic [15:0] attack_length;
        logic [23:0] attack_slope;
        logic [15:0] release_length;
        logic [23:0] release_slope;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        phase_step:     32'd0,
        note_length:    24'd0,
        loudness:       16'd0,
        attack_length:  16'd2400,
        attack_slope:   24'd6991,
        release_length: 16'd3840,
        release_slope:  24'd4369
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV,
        ST_HARM,
        ST_SUM,
        ST_MAG,
        ST_SCALE,
        ST_SCALE_RND,
        ST_LOUD,
        ST_DONE
    } t_state;

endpackage

FILE: sv/ahv_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice configuration registers
// Decodes the write port into the seven voice settings.
// ----------------------------------------------------------------------------
module ahv_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ahv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ahv_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ahv_pkg::t_cfg                      o_cfg
);

    ahv_pkg::t_cfg r_cfg;
    ahv_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (ahv_pkg::t_cfg_idx'(i_cfg_index))
                ahv_pkg::CFG_PHASE_STEP:     n_cfg.phase_step     = i_cfg_data[31:0];
                ahv_pkg::CFG_NOTE_LENGTH:    n_cfg.note_length    = i_cfg_data[23:0];
                ahv_pkg::CFG_LOUDNESS:       n_cfg.loudness       = i_cfg_data[15:0];
                ahv_pkg::CFG_ATTACK_LENGTH:  n_cfg.attack_length  = i_cfg_data[15:0];
                ahv_pkg::CFG_ATTACK_SLOPE:   n_cfg.attack_slope   = i_cfg_data[23:0];
                ahv_pkg::CFG_RELEASE_LENGTH: n_cfg.release_length = i_cfg_data[15:0];
                ahv_pkg::CFG_RELEASE_SLOPE:  n_cfg.release_slope  = i_cfg_data[23:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ahv_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/ahv_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Magnitude of sin over the first quadrant, sampled at bin centers, with a
// registered read. The table is built at elaboration from a fixed-point
// Taylor series.
// ----------------------------------------------------------------------------
module ahv_sine_rom #(
    parameter int SINE_ADDRESS_BITS = 10,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                         i_clk,
    input  logic [SINE_ADDRESS_BITS-1:0] i_addr,
    output logic [SAMPLE_BITS-2:0]       o_data
);

    localparam int ROM_SIZE = 1 << SINE_ADDRESS_BITS;
    localparam int AMP_W    = SAMPLE_BITS - 1;
    localparam logic [63:0] ROM_AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [AMP_W-1:0] t_rom [ROM_SIZE];

    // Series to the x^13 term in Q2.30; every step truncates.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] term;
        for (int a = 0; a < ROM_SIZE; a++) begin
            x    = (ahv_pkg::HALF_PI_Q30 * (64'(2 * a) + 64'd1)) >> (SINE_ADDRESS_BITS + 1);
            x2   = (x * x) >> 30;
            acc  = x;
            term = x;
            term = ((term * x2) >> 30) / 64'd6;
            acc  = (term > acc) ? 64'd0 : acc - term;
            term = ((term * x2) >> 30) / 64'd20;
            acc  = acc + term;
            term = ((term * x2) >> 30) / 64'd42;
            acc  = (term > acc) ? 64'd0 : acc - term;
            term = ((term * x2) >> 30) / 64'd72;
            acc  = acc + term;
            term = ((term * x2) >> 30) / 64'd110;
            acc  = (term > acc) ? 64'd0 : acc - term;
            term = ((term * x2) >> 30) / 64'd156;
            acc  = acc + term;
            if (acc > ONE_Q30) begin
                acc = ONE_Q30;
            end
            rom[a] = AMP_W'((acc * ROM_AMP + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam t_rom SINE_TABLE = build_rom();

    logic [AMP_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: sv/ahv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product that holds while not enabled.
// ----------------------------------------------------------------------------
module ahv_mul #(
    parameter int WIDTH = 26
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [WIDTH-1:0] i_a,
    input  logic signed [WIDTH-1:0] i_b,
    output logic [2*WIDTH-1:0]     o_p
);

    logic signed [2*WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

FILE: sv/additive_harmonic_voice_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive harmonic voice unit
// One voice sample per input word: four weighted harmonics from a sine ROM,
// shaped by a linear attack/release envelope and a loudness gain.
// ----------------------------------------------------------------------------
// Each accepted input word yields exactly one output word. A sounding sample
// passes ENV, HARM for each of the four harmonics, SUM, MAG, SCALE, SCALE_RND,
// LOUD and DONE into the output register; a silent tick (no note playing)
// goes from idle to DONE. o_in_ready is high only while the sequencer is
// idle, so the next input word is taken in the cycle after the load at the
// earliest. The steps are set by the single shared multiplier, which serves
// in turn the envelope ramp, the four harmonic weights, the envelope gain and
// the loudness gain, with accumulate and rounding steps between.
// The finished word sits in an output register, so the unit returns to idle
// and takes the next input word while a result still waits downstream; it
// only stalls when a second result is ready before the first was taken.
// The quarter-wave sine table has 2^SINE_ADDRESS_BITS entries, is built at
// elaboration and needs no fill after reset. A start request restarts the
// note at index 0 with phase 0. Configuration is written through a plain
// write port and is expected to change only while the unit is idle.
// ----------------------------------------------------------------------------
`include "additive_harmonic_voice_unit_defines.svh"

module additive_harmonic_voice_unit #(
    parameter int PHASE_BITS        = 32,
    parameter int SINE_ADDRESS_BITS = 10,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ahv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ahv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_start_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ahv_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_last,
    output logic                                o_active
);

    // Multiplier operands must hold a 25-bit envelope gain and the rounded
    // magnitude, both unsigned, next to a signed sine value.
    localparam int MUL_W  = (SAMPLE_BITS + 2 > ahv_pkg::ENV_W + 1) ?
                            SAMPLE_BITS + 2 : ahv_pkg::ENV_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int AMP_W  = SAMPLE_BITS - 1;
    // Weighted harmonic sum stays below 2^(SAMPLE_BITS+16) in magnitude.
    localparam int SUM_W  = SAMPLE_BITS + 17;
    localparam int M_W    = SAMPLE_BITS + 1;
    localparam int IDX_W  = ahv_pkg::IDX_W;
    localparam int ENV_W  = ahv_pkg::ENV_W;
    localparam int RES_W  = ahv_pkg::RES_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    ahv_pkg::t_cfg cfg;

    ahv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ahv_pkg::t_state r_state, n_state;

    logic [PHASE_BITS-1:0] r_phase_acc, n_phase_acc;
    logic [PHASE_BITS-1:0] r_ph, n_ph;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_playing, n_playing;
    logic                  r_out_valid, n_out_valid;

    logic [IDX_W-1:0]         r_i, n_i;
    logic                     r_active, n_active;
    logic                     r_last, n_last;
    logic [1:0]               r_k, n_k;
    logic                     r_rom_neg;
    logic                     r_env_one, n_env_one;
    logic [ENV_W-1:0]         r_env, n_env;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [M_W-1:0]           r_m, n_m;
    logic                     r_neg, n_neg;
    logic [ahv_pkg::SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                     r_out_last, n_out_last;
    logic                     r_out_active, n_out_active;

    // ------------------------------------------------------------------
    // Sine ROM, addressed from the current harmonic phase
    // ------------------------------------------------------------------
    logic [1:0]                   rom_quad;
    logic [SINE_ADDRESS_BITS-1:0] rom_addr;
    logic [AMP_W-1:0]             rom_data;

    assign rom_quad = r_ph[PHASE_BITS-1 -: 2];
    assign rom_addr = rom_quad[0] ? ~r_ph[PHASE_BITS-3 -: SINE_ADDRESS_BITS]
                                  :  r_ph[PHASE_BITS-3 -: SINE_ADDRESS_BITS];

    ahv_sine_rom #(
        .SINE_ADDRESS_BITS (SINE_ADDRESS_BITS),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0]        prod;

    ahv_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic [IDX_W-1:0]      idx_eff;
    logic [IDX_W:0]        idx_inc;
    logic                  play_eff;
    logic                  sound;
    logic [PHASE_BITS-1:0] phase_base;
    logic [PHASE_BITS-1:0] phase_next;

    logic                  env_att;
    logic [IDX_W-1:0]      env_rem;
    logic                  env_rel;
    logic [ENV_W-1:0]      env_next;

    logic [MUL_W-1:0]      sine_mag;
    logic [MUL_W-1:0]      sine_val;
    logic signed [SUM_W-1:0] prod_sum;
    logic [SUM_W-1:0]      sum_mag;
    logic [SUM_W-1:0]      mag_rnd;
    logic [PROD_W-1:0]     scale_rnd;
    logic [PROD_W-1:0]     loud_rnd;
    logic [RES_W-1:0]      level;
    logic [ahv_pkg::SAMPLE_W-1:0] sat_sample;

    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_eff    = i_start_req ? '0 : r_idx;
    assign idx_inc    = {1'b0, idx_eff} + 1'b1;
    assign play_eff   = i_start_req || r_playing;
    assign sound      = play_eff && (idx_eff < cfg.note_length);
    assign phase_base = i_start_req ? '0 : r_phase_acc;
    assign phase_next = phase_base + PHASE_BITS'(cfg.phase_step);

    // Attack ramp wins over release; otherwise the gain is unity.
    assign env_att  = r_i < IDX_W'(cfg.attack_length);
    assign env_rem  = cfg.note_length - r_i;
    assign env_rel  = env_rem < IDX_W'(cfg.release_length);
    assign env_next = r_env_one ? ahv_pkg::ENV_ONE :
                      (prod > PROD_W'(ahv_pkg::ENV_ONE)) ? ahv_pkg::ENV_ONE :
                      prod[ENV_W-1:0];

    assign sine_mag = MUL_W'(rom_data);
    assign sine_val = r_rom_neg ? (~sine_mag + 1'b1) : sine_mag;
    assign prod_sum = $signed(prod[SUM_W-1:0]);

    // Magnitude rounding steps are half away from zero.
    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mag_rnd   = sum_mag + SUM_W'(1 << (ahv_pkg::MAG_FRAC - 1));
    assign scale_rnd = prod + PROD_W'(ahv_pkg::ENV_HALF);
    assign loud_rnd  = prod + (PROD_W'(1) << SAMPLE_BITS);
    assign level     = loud_rnd[SAMPLE_BITS+1 +: RES_W];

    always_comb begin
        if (r_neg) begin
            sat_sample = (level > ahv_pkg::NEG_LIMIT) ? ahv_pkg::NEG_SAT :
                         ahv_pkg::SAMPLE_W'(~level + 1'b1);
        end else begin
            sat_sample = (level > ahv_pkg::POS_LIMIT) ? ahv_pkg::POS_SAT :
                         level[ahv_pkg::SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_phase_acc  = r_phase_acc;
        n_ph         = r_ph;
        n_idx        = r_idx;
        n_playing    = r_playing;
        n_i          = r_i;
        n_active     = r_active;
        n_last       = r_last;
        n_k          = r_k;
        n_env_one    = r_env_one;
        n_env        = r_env;
        n_sum        = r_sum;
        n_m          = r_m;
        n_neg        = r_neg;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        n_out_active = r_out_active;
        n_out_valid  = r_out_valid && !i_out_ready;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        unique case (r_state)
            ahv_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (sound) begin
                        // Phase advances before the sample is formed.
                        n_phase_acc = phase_next;
                        n_ph        = phase_next;
                        n_i         = idx_eff;
                        n_idx       = idx_inc[IDX_W-1:0];
                        n_playing   = idx_inc < {1'b0, cfg.note_length};
                        n_last      = idx_inc == {1'b0, cfg.note_length};
                        n_active    = 1'b1;
                        n_state     = ahv_pkg::ST_ENV;
                    end else begin
                        n_phase_acc = phase_base;
                        n_idx       = idx_eff;
                        n_playing   = 1'b0;
                        n_last      = 1'b0;
                        n_active    = 1'b0;
                        n_state     = ahv_pkg::ST_DONE;
                    end
                end
            end
            ahv_pkg::ST_ENV: begin
                mul_en    = 1'b1;
                mul_a     = env_att ? MUL_W'(r_i) : MUL_W'(env_rem);
                mul_b     = env_att ? MUL_W'(cfg.attack_slope) : MUL_W'(cfg.release_slope);
                n_env_one = !env_att && !env_rel;
                n_ph      = r_ph + r_phase_acc;
                n_k       = '0;
                n_state   = ahv_pkg::ST_HARM;
            end
            ahv_pkg::ST_HARM: begin
                // One harmonic per pass; the product of the previous one
                // is folded into the sum while the next is multiplied.
                mul_en = 1'b1;
                mul_a  = sine_val;
                mul_b  = MUL_W'(ahv_pkg::HARM_WEIGHT[r_k]);
                n_ph   = r_ph + r_phase_acc;
                if (r_k == 2'd0) begin
                    n_env = env_next;
                    n_sum = '0;
                end else begin
                    n_sum = r_sum + prod_sum;
                end
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = ahv_pkg::ST_SUM;
                end
            end
            ahv_pkg::ST_SUM: begin
                n_sum   = r_sum + prod_sum;
                n_state = ahv_pkg::ST_MAG;
            end
            ahv_pkg::ST_MAG: begin
                n_neg   = r_sum[SUM_W-1];
                n_m     = mag_rnd[ahv_pkg::MAG_FRAC +: M_W];
                n_state = ahv_pkg::ST_SCALE;
            end
            ahv_pkg::ST_SCALE: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_m);
                mul_b   = MUL_W'(r_env);
                n_state = ahv_pkg::ST_SCALE_RND;
            end
            ahv_pkg::ST_SCALE_RND: begin
                n_m     = scale_rnd[ahv_pkg::ENV_FRAC +: M_W];
                n_state = ahv_pkg::ST_LOUD;
            end
            ahv_pkg::ST_LOUD: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(r_m);
                mul_b   = MUL_W'(cfg.loudness);
                n_state = ahv_pkg::ST_DONE;
            end
            ahv_pkg::ST_DONE: begin
                // Load the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_active ? sat_sample : '0;
                    n_out_last   = r_last;
                    n_out_active = r_active;
                    n_state      = ahv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ahv_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ahv_pkg::ST_IDLE;
            r_phase_acc <= '0;
            r_idx       <= '0;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase_acc <= n_phase_acc;
            r_idx       <= n_idx;
            r_playing   <= n_playing;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph         <= n_ph;
        r_i          <= n_i;
        r_active     <= n_active;
        r_last       <= n_last;
        r_k          <= n_k;
        r_rom_neg    <= rom_quad[1];
        r_env_one    <= n_env_one;
        r_env        <= n_env;
        r_sum        <= n_sum;
        r_m          <= n_m;
        r_neg        <= n_neg;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_active <= n_out_active;
    end

    assign o_in_ready  = r_state == ahv_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_out_sample);
    assign o_last      = r_out_last;
    assign o_active    = r_out_active;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AHV_ASSERT_IMP(a_silent_word_zero, o_out_valid && !o_active,
                    o_sample == '0 && !o_last, "silent word carries sample or last")
    `AHV_ASSERT_IMP(a_last_is_active, o_out_valid && o_last, o_active,
                    "last flagged on a silent word")
    `AHV_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
                     "ready right after accepting a word")
    `AHV_ASSERT_IMP(a_harm_only_sounding, r_state == ahv_pkg::ST_HARM, r_active,
                    "harmonics computed for a silent tick")

endmodule

FILE: test/additive_harmonic_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive harmonic voice checker
// Watches the register port and both word channels of the voice unit, keeps
// its own copy of the voice state, predicts every output word and compares it
// field by field with what the unit delivers.
// ----------------------------------------------------------------------------
module additive_harmonic_voice_checker
    import ahv_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_start_req,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic                       i_active,
    input  logic                       i_test_done,
    output int                         o_fail_count
);

    localparam int TABLE_BITS  = 10;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       active;
    } t_voice_word;

    logic [SAMPLE_W-1:0] quarter_sine [TABLE_SIZE];
    t_cfg                regs;
    logic [31:0]         phase;
    logic [IDX_W-1:0]    note_pos;
    logic                sounding;
    t_voice_word         expected_words [$];
    int                  pending       = 0;
    int                  mismatches    = 0;
    int                  words_checked = 0;

    // Words still owed at the end of the run count as failures.
    assign o_fail_count = mismatches + (i_test_done ? pending : 0);

    // One quarter-wave entry: sine at the middle of the address bin, from a
    // Taylor series in Q2.30 with truncating steps.
    function automatic logic [SAMPLE_W-1:0] taylor_sine_entry(int unsigned addr);
        longint unsigned x, x2, acc, term;
        x    = (HALF_PI_Q30 * (64'(addr) * 2 + 1)) / (64'd2 * TABLE_SIZE);
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (term > acc) ? 64'd0 : acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc > (64'd1 << 30)) begin
            acc = 64'd1 << 30;
        end
        return SAMPLE_W'((acc * ((64'd1 << (SAMPLE_W - 1)) - 1) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint signed_sine(logic [31:0] ph);
        logic [1:0]            quad;
        logic [TABLE_BITS-1:0] addr;
        quad = ph[31:30];
        addr = ph[29 -: TABLE_BITS];
        if (quad[0]) begin
            addr = ~addr;
        end
        return quad[1] ? -longint'(quarter_sine[addr]) : longint'(quarter_sine[addr]);
    endfunction

    function automatic longint unsigned envelope_gain(logic [IDX_W-1:0] pos);
        longint unsigned gain, remaining;
        remaining = 64'(regs.note_length) - 64'(pos);
        if (64'(pos) < 64'(regs.attack_length)) begin
            gain = 64'(pos) * 64'(regs.attack_slope);
        end else if (remaining < 64'(regs.release_length)) begin
            gain = remaining * 64'(regs.release_slope);
        end else begin
            gain = 64'(ENV_ONE);
        end
        return (gain > 64'(ENV_ONE)) ? 64'(ENV_ONE) : gain;
    endfunction

    // Advances the voice by one tick and returns the word it should produce.
    function automatic t_voice_word next_voice_word(logic start);
        t_voice_word      w;
        logic [IDX_W-1:0] pos;
        logic [31:0]      ph;
        longint           mix;
        longint unsigned  mag, gain;
        bit               neg;
        w = '0;
        if (start) begin
            phase    = '0;
            note_pos = '0;
            sounding = 1'b1;
        end
        if (sounding && note_pos >= regs.note_length) begin
            sounding = 1'b0;
        end
        if (!sounding) begin
            return w;
        end
        pos   = note_pos;
        gain  = envelope_gain(pos);
        phase = phase + regs.phase_step;
        mix   = 0;
        for (int k = 1; k <= 4; k++) begin
            ph  = phase * 32'(k);
            mix = mix + signed_sine(ph) * longint'(HARM_WEIGHT[k-1]);
        end
        neg = (mix < 0);
        mag = neg ? -mix : mix;
        mag = (mag + (64'd1 << (MAG_FRAC - 1))) >> MAG_FRAC;
        mag = (mag * gain + (64'd1 << (ENV_FRAC - 1))) >> ENV_FRAC;
        mag = (mag * 64'(regs.loudness) + (64'd1 << SAMPLE_W)) >> (SAMPLE_W + 1);
        if (neg) begin
            w.sample = (mag > 64'd32768) ? NEG_SAT : SAMPLE_W'(-mag);
        end else begin
            w.sample = (mag > 64'd32767) ? POS_SAT : SAMPLE_W'(mag);
        end
        w.last   = (32'(pos) + 1 == 32'(regs.note_length));
        w.active = 1'b1;
        note_pos = pos + 1'b1;
        if (32'(pos) + 1 >= 32'(regs.note_length)) begin
            sounding = 1'b0;
        end
        return w;
    endfunction

    initial begin
        for (int a = 0; a < TABLE_SIZE; a++) begin
            quarter_sine[a] = taylor_sine_entry(a);
        end
    end

    always @(posedge i_clk) begin
        t_voice_word want, got;
        if (!i_rst_n) begin
            regs     = CFG_RESET;
            phase    = '0;
            note_pos = '0;
            sounding = 1'b0;
            expected_words.delete();
            pending  = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PHASE_STEP:     regs.phase_step     = i_cfg_data;
                    CFG_NOTE_LENGTH:    regs.note_length    = i_cfg_data[23:0];
                    CFG_LOUDNESS:       regs.loudness       = i_cfg_data[15:0];
                    CFG_ATTACK_LENGTH:  regs.attack_length  = i_cfg_data[15:0];
                    CFG_ATTACK_SLOPE:   regs.attack_slope   = i_cfg_data[23:0];
                    CFG_RELEASE_LENGTH: regs.release_length = i_cfg_data[15:0];
                    CFG_RELEASE_SLOPE:  regs.release_slope  = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(next_voice_word(i_start_req));
                pending++;
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_sample, i_last, i_active};
                if (expected_words.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("Voice word %0d arrived with nothing expected: sample %0d",
                                 words_checked, got.sample);
                    end
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    pending--;
                    if (got.sample !== want.sample || got.last !== want.last ||
                        got.active !== want.active) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display({"Voice word %0d: expected sample %0d last %b active %b,",
                                      " got sample %0d last %b active %b"},
                                     words_checked, want.sample, want.last, want.active,
                                     got.sample, got.last, got.active);
                        end
                        mismatches++;
                    end
                end
                words_checked++;
            end
        end
    end

    always @(posedge i_test_done) begin
        if (pending != 0) begin
            $display("%0d expected voice words never arrived.", pending);
        end
    end

endmodule

FILE: test/additive_harmonic_voice_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive harmonic voice unit testbench
// Drives start and continue ticks into the voice unit under a series of
// register settings, with random idle time on both word channels, and lets
// the checker compare every output word against its own prediction.
// ----------------------------------------------------------------------------
module additive_harmonic_voice_unit_test;
    import ahv_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_start_req;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                  o_last;
    logic                  o_active;

    logic test_done = 1'b0;
    int   fail_count;

    // Handshakes seen on each channel, plus what the output words carried.
    int words_in       = 0;
    int words_out      = 0;
    int sounding_words = 0;
    int note_ends      = 0;
    int cycle_count    = 0;

    // Sender side bookkeeping: restarts issued, ticks since the last start and
    // the note length currently programmed, used to decide when to restart.
    int          restarts    = 0;
    int          since_start = 0;
    int          reg_writes  = 0;
    logic [23:0] note_len    = '0;

    // Shared controls: steady turns off idling on both sides, and hold_req
    // asks the receiver for one long stretch with ready low.
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    additive_harmonic_voice_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample),
        .o_last      (o_last),
        .o_active    (o_active)
    );

    additive_harmonic_voice_checker voice_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_start_req  (i_start_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample     (o_sample),
        .i_last       (o_last),
        .i_active     (o_active),
        .i_test_done  (test_done),
        .o_fail_count (fail_count)
    );

    // Idle lengths: mostly a few cycles, now and then a long pause.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 90);
    endfunction

    // Envelope slope for a ramp: either random over the whole range, the
    // largest value (the ramp all but reaches unity at once), or a slope that just
    // about reaches unity at the end of the ramp.
    function automatic logic [31:0] ramp_slope(logic [15:0] len);
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(0, 24'hFF_FFFF));
            1:       return 32'h00FF_FFFF;
            default: return 32'(ENV_ONE) / (32'(len) + 1) + $urandom_range(0, 15);
        endcase
    endfunction

    // Offers one tick word after an optional gap and returns at the edge where
    // it was taken. With no gap, valid simply stays high for the next word.
    task automatic send_word(input logic start, input int unsigned gap);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_in_ready);
        if (start) begin
            restarts++;
            since_start = 0;
        end else begin
            since_start++;
        end
    endtask

    // Stops offering words and waits until every word sent has come back, so
    // the unit is idle and registers may be written.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_out != words_in) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_writes++;
        if (idx == CFG_NOTE_LENGTH) begin
            note_len = value[23:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                words_in <= words_in + 1;
            end
            if (o_out_valid && i_out_ready) begin
                words_out <= words_out + 1;
                if (o_active) begin
                    sounding_words <= sounding_words + 1;
                end
                if (o_last) begin
                    note_ends <= note_ends + 1;
                end
            end
        end
    end

    // Receiver: random stalls, no stalls in steady stretches, and one long
    // hold-off on request that lets the unit fill up and refuse input.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req    <= 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = idle_length() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("[additive_harmonic_voice_unit] ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] step;
        logic [23:0] length;
        logic [15:0] attack_len, release_len;
        logic        start;
        int unsigned gap;
        bit          burst;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_start_req <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings have a zero note length: a plain tick is silent, and
        // a start on a zero-length note plays nothing.
        send_word(1'b0, 0);
        send_word(1'b1, 0);

        // A six-sample note at full loudness with the largest phase step: a
        // steep attack ramp, a release ramp, the last flag, and silence
        // after the note has ended.
        drain_results();
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_NOTE_LENGTH, 32'd6);
        write_reg(CFG_LOUDNESS, 32'hFFFF);
        write_reg(CFG_ATTACK_LENGTH, 32'd2);
        write_reg(CFG_ATTACK_SLOPE, 32'hFF_FFFF);
        write_reg(CFG_RELEASE_LENGTH, 32'd3);
        write_reg(CFG_RELEASE_SLOPE, 32'h40_0000);
        send_word(1'b1, 0);
        repeat (7) send_word(1'b0, $urandom_range(0, 2));

        // Shortened note: the length drops below the current index while the
        // note plays, which silences it at once.
        drain_results();
        write_reg(CFG_PHASE_STEP, 32'h0123_4567);
        write_reg(CFG_NOTE_LENGTH, 32'd20);
        write_reg(CFG_LOUDNESS, 32'h8000);
        write_reg(CFG_ATTACK_LENGTH, 32'd0);
        write_reg(CFG_RELEASE_LENGTH, 32'd0);
        send_word(1'b1, 0);
        repeat (3) send_word(1'b0, 0);
        drain_results();
        write_reg(CFG_NOTE_LENGTH, 32'd3);
        send_word(1'b0, 0);

        // Raising the length again does not revive the note; a start does,
        // and a second start restarts it in the middle.
        drain_results();
        write_reg(CFG_NOTE_LENGTH, 32'd20);
        send_word(1'b0, 0);
        send_word(1'b1, 0);
        send_word(1'b0, 0);
        send_word(1'b1, 0);

        // Length lowered to exactly the current index also ends the note.
        drain_results();
        write_reg(CFG_NOTE_LENGTH, 32'd1);
        send_word(1'b0, 0);

        // Longest note with zero phase step, zero slopes and zero loudness,
        // then the same note at full gain with no ramps.
        drain_results();
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_NOTE_LENGTH, 32'hFF_FFFF);
        write_reg(CFG_LOUDNESS, 32'd0);
        write_reg(CFG_ATTACK_LENGTH, 32'hFFFF);
        write_reg(CFG_ATTACK_SLOPE, 32'd0);
        write_reg(CFG_RELEASE_LENGTH, 32'hFFFF);
        write_reg(CFG_RELEASE_SLOPE, 32'd0);
        send_word(1'b1, 0);
        send_word(1'b0, 0);
        drain_results();
        write_reg(CFG_LOUDNESS, 32'hFFFF);
        write_reg(CFG_ATTACK_LENGTH, 32'd0);
        write_reg(CFG_RELEASE_LENGTH, 32'd0);
        send_word(1'b1, 0);
        repeat (2) send_word(1'b0, 0);

        // Random part: each phase programs a fresh setting while idle, then
        // plays mostly well-formed notes, restarting soon after a note ends
        // and only rarely in the middle of one.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();

            if (p == 0) begin
                step = 32'hFFFF_FFFF;
            end else if (p == 1) begin
                step = 32'd0;
            end else if ($urandom_range(0, 2) == 0) begin
                step = $urandom_range(1, 32'h0010_0000);
            end else begin
                step = $urandom();
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: length = 24'($urandom_range(1, 60));
                7, 8:                length = 24'($urandom_range(61, 400));
                default:             length = 24'($urandom());
            endcase
            if (p == 1) begin
                length = 24'd1;
            end else if (p == RANDOM_PHASES - 1) begin
                length = 24'hFF_FFFF;
            end

            attack_len  = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                                                        16'($urandom_range(0, 30));
            release_len = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                                                        16'($urandom_range(0, 30));

            write_reg(CFG_PHASE_STEP, step);
            write_reg(CFG_NOTE_LENGTH, 32'(length));
            write_reg(CFG_LOUDNESS, (p == 0 || $urandom_range(0, 3) == 0) ?
                                    32'hFFFF : $urandom_range(0, 16'hFFFF));
            write_reg(CFG_ATTACK_LENGTH, 32'(attack_len));
            write_reg(CFG_ATTACK_SLOPE, ramp_slope(attack_len));
            write_reg(CFG_RELEASE_LENGTH, 32'(release_len));
            write_reg(CFG_RELEASE_SLOPE, ramp_slope(release_len));

            steady = (p % 4 == 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // In one phase the receiver holds off for a long stretch while
                // words keep coming back to back, so the unit fills and stalls.
                burst = (p == 3 && n >= 10 && n < 40);
                if (p == 3 && n == 10) begin
                    hold_req <= 1'b1;
                end
                // In another the sender pauses until every result is back.
                if (p == 5 && n == 40) begin
                    drain_results();
                end
                if (n == 0) begin
                    start = 1'b1;
                end else if (since_start >= int'(note_len)) begin
                    start = ($urandom_range(0, 3) == 0);
                end else begin
                    start = ($urandom_range(0, 39) == 0);
                end
                gap = (steady || burst || $urandom_range(0, 2) != 0) ? 0 : idle_length();
                send_word(start, gap);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        test_done <= 1'b1;
        @(posedge i_clk);

        $display("Ran %0d tick words: %0d sounding samples, %0d note ends, %0d starts.",
                 words_out, sounding_words, note_ends, restarts);
        $display("Used %0d register writes over directed and %0d random settings.",
                 reg_writes, RANDOM_PHASES);
        if (fail_count == 0) begin
            $display("[additive_harmonic_voice_unit] OK");
        end else begin
            $display("[additive_harmonic_voice_unit] ERROR");
        end
        $finish;
    end

endmodule
